[rtl/fmr_pkg.sv]
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types, constants and functions of the framed message receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package fmr_pkg;

  localparam logic [7:0]  MAX_BODY      = 8'd128;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] START_RESET   = 32'h1857_FC0A;
  localparam logic [7:0]  MAXLEN_RESET  = 8'd128;

  localparam logic [7:0]  CHAR_A = 8'h41;
  localparam logic [7:0]  CHAR_C = 8'h43;
  localparam logic [7:0]  CHAR_K = 8'h4B;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_LW    = $clog2(OQ_DEPTH + 1);

  // Configuration register indexes
  localparam logic REG_START  = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  typedef enum logic [2:0] {
    KIND_BODY    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_ACK     = 3'd2,
    KIND_CRC_ERR = 3'd3,
    KIND_LEN_ERR = 3'd4,
    KIND_HDR_ERR = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] msg_index;
    logic [31:0] body_length;
    logic        ack_wanted;
    logic        sequence_gap;
    logic [31:0] crc_fail_total;
    logic        last;
  } res_t;

  // Valid flags of the results handed from the frame engine to the output queue
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] ack_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CHAR_A;
      2'd1:    ch = CHAR_C;
      2'd2:    ch = CHAR_K;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/framed_message_receiver_top.sv]
// ----------------------------------------------------------------------------
// framed_message_receiver_top
// Byte-stream frame receiver with header check and CRC-32 body check.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_stall is low. Each byte passes an
// input register and is fully processed once the output queue has room
// (start hunt, header sum, byte-wide CRC-32), writing its results into a
// four-word output queue. The output side delivers one word per cycle while
// out_stall is low; the last byte of a body yields two words (the body byte
// and the end-of-message word). in_stall rises while a byte is held in the
// input register and the queue holds more than two words.
`default_nettype none

module framed_message_receiver_top
  import fmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [31:0]      out_msg_index,
  output logic [31:0]      out_body_length,
  output logic             out_ack_wanted,
  output logic             out_sequence_gap,
  output logic [31:0]      out_crc_fail_total,
  output logic             out_last
);

  logic [31:0]      start_pattern_r;
  logic [7:0]       max_len_r;
  logic             room;
  logic [OQ_LW-1:0] level;
  push_t            push;
  res_t             res0, res1, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pattern_r <= START_RESET;
      max_len_r       <= MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:  start_pattern_r <= cfg_wdata;
        REG_MAXLEN: max_len_r       <= cfg_wdata[7:0];
        default:    start_pattern_r <= start_pattern_r;
      endcase
    end
  end

  fmr_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .start_pattern   (start_pattern_r),
    .max_body_length (max_len_r),
    .room            (room),
    .push            (push),
    .res0            (res0),
    .res1            (res1)
  );

  fmr_out_fifo u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_msg_index      = out_res.msg_index;
  assign out_body_length    = out_res.body_length;
  assign out_ack_wanted     = out_res.ack_wanted;
  assign out_sequence_gap   = out_res.sequence_gap;
  assign out_crc_fail_total = out_res.crc_fail_total;
  assign out_last           = out_res.last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= OQ_LW'(OQ_DEPTH))
    else $error("output queue overflow");

  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && (res0.kind == KIND_BODY) && !res0.last && res1.last))
    else $error("two-word push not body byte plus end word");

  a_nonlast_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_kind == KIND_BODY))
    else $error("non-final word is not a body byte");

  a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 || push.v1) |-> room)
    else $error("push while queue lacks room");

endmodule

`default_nettype wire

[rtl/fmr_out_fifo.sv]
// ----------------------------------------------------------------------------
// fmr_out_fifo
// Result queue: takes up to two results per cycle, delivers one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_out_fifo
  import fmr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire push_t            push,
  input  wire res_t             res0,
  input  wire res_t             res1,
  output logic                  room,
  output logic [OQ_LW-1:0]      level,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output res_t                  out_res
);

  res_t              mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OQ_LW-1:0]  level_r, level_nxt;
  logic              pop;
  logic [1:0]        n_push;

  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign out_valid = (level_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = mem_r[rd_ptr_r];
  assign room      = (level_r <= OQ_LW'(OQ_DEPTH - 2));
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
    level_nxt  = level_r + OQ_LW'(n_push) - OQ_LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + OQ_AW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

[rtl/fmr_core.sv]
// ----------------------------------------------------------------------------
// fmr_core
// Frame engine: input byte register, start hunt, header collect and check,
// body CRC and end-of-message decision.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_core
  import fmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [31:0] start_pattern,
  input  wire logic [7:0]  max_body_length,
  input  wire logic        room,
  output push_t            push,
  output res_t             res0,
  output res_t             res1
);

  // input stage
  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        accept, fire;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [4:0]  hcount_r, hcount_nxt;
  logic [7:0]  hb_r [16];
  logic [15:0] hsum_r, hsum_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [1:0]  ackm_r, ackm_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] fail_r, fail_nxt;

  // derived
  logic [31:0] idx_w, len_w, crc_w;
  logic        ack_byte_set;
  logic [7:0]  limit;
  logic        len_bad, sum_bad;
  logic [15:0] chk;
  logic        hdr_last, body_end, hdr_fin, finish;
  logic [31:0] crc_b, crc_fin;
  logic [7:0]  pos;
  logic        ack_hit;
  logic [1:0]  ack_inc;
  logic [1:0]  ackm_fin;
  logic        crc_ok, is_ack, gap;
  logic [31:0] win_shift;
  res_t        fin_res, base_res;

  assign accept   = in_valid && !in_stall;
  assign fire     = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  // decode of the stored header and the current byte
  always_comb begin
    idx_w        = {hb_r[3], hb_r[2], hb_r[1], hb_r[0]};
    len_w        = {hb_r[7], hb_r[6], hb_r[5], hb_r[4]};
    crc_w        = {hb_r[11], hb_r[10], hb_r[9], hb_r[8]};
    ack_byte_set = (hb_r[12] != 8'd0);
    limit        = (max_body_length > MAX_BODY) ? MAX_BODY : max_body_length;
    len_bad      = (len_w > {24'd0, limit});
    chk          = {byte_r, hb_r[14]};
    sum_bad      = (hsum_r != chk);
    hdr_last     = (phase_r == PH_HEADER) && (hcount_r[3:0] == 4'd15);
    body_end     = (phase_r == PH_BODY) && (rem_r <= 8'd1);
    hdr_fin      = hdr_last && !len_bad && !sum_bad && (len_w[7:0] == 8'd0);
    finish       = hdr_fin || body_end;
    win_shift    = {byte_r, window_r[31:8]};

    crc_b        = crc_byte(crc_r, byte_r);
    pos          = len_w[7:0] - rem_r;
    ack_hit      = (pos < 8'd3) && (ackm_r == pos[1:0]) && (byte_r == ack_char(pos[1:0]));
    ack_inc      = ackm_r + 2'(ack_hit);

    crc_fin      = hdr_fin ? 32'hFFFF_FFFF : crc_b;
    ackm_fin     = hdr_fin ? 2'd0 : ack_inc;
    crc_ok       = (~crc_fin == crc_w);
    is_ack       = crc_ok && (len_w == 32'd3) && (ackm_fin == 2'd3);
    gap          = (idx_w != prev_r + 32'd1);
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    hcount_nxt = hcount_r;
    hsum_nxt   = hsum_r;
    rem_nxt    = rem_r;
    crc_nxt    = crc_r;
    ackm_nxt   = ackm_r;
    prev_nxt   = prev_r;
    fail_nxt   = fail_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (hcount_r < 5'd14) begin
          hsum_nxt = hsum_r + {8'd0, byte_r};
        end
        hcount_nxt = hcount_r + 5'd1;
        if (hdr_last) begin
          hcount_nxt = 5'd0;
          if (len_bad || sum_bad) begin
            phase_nxt = PH_HUNT;
          end else begin
            rem_nxt   = len_w[7:0];
            crc_nxt   = 32'hFFFF_FFFF;
            ackm_nxt  = 2'd0;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_nxt  = crc_b;
        ackm_nxt = ack_inc;
        if (rem_r != 8'd0) begin
          rem_nxt = rem_r - 8'd1;
        end
      end
      default: begin
        phase_nxt  = PH_HUNT;
        window_nxt = win_shift;
        if (win_shift == start_pattern) begin
          phase_nxt  = PH_HEADER;
          hcount_nxt = 5'd0;
          hsum_nxt   = 16'({8'd0, win_shift[7:0]} + {8'd0, win_shift[15:8]}
                         + {8'd0, win_shift[23:16]} + {8'd0, win_shift[31:24]});
        end
      end
    endcase
    if (finish) begin
      phase_nxt  = PH_HUNT;
      window_nxt = 32'd0;
      if (!crc_ok) begin
        fail_nxt = fail_r + 32'd1;
      end else if (!is_ack) begin
        prev_nxt = idx_w;
      end
    end
  end

  // results
  always_comb begin
    base_res                = '0;
    base_res.kind           = KIND_BODY;
    base_res.msg_index      = idx_w;
    base_res.body_length    = len_w;
    base_res.crc_fail_total = fail_r;

    fin_res                = base_res;
    fin_res.last           = 1'b1;
    fin_res.crc_fail_total = fail_nxt;
    if (!crc_ok) begin
      fin_res.kind = KIND_CRC_ERR;
    end else if (is_ack) begin
      fin_res.kind = KIND_ACK;
    end else begin
      fin_res.kind         = KIND_GOOD;
      fin_res.ack_wanted   = ack_byte_set;
      fin_res.sequence_gap = gap;
    end

    push = '0;
    res0 = base_res;
    res1 = fin_res;
    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_last) begin
          res0.last = 1'b1;
          if (len_bad) begin
            push.v0   = 1'b1;
            res0.kind = KIND_LEN_ERR;
          end else if (sum_bad) begin
            push.v0   = 1'b1;
            res0.kind = KIND_HDR_ERR;
          end else if (hdr_fin) begin
            push.v0 = 1'b1;
            res0    = fin_res;
          end
        end
      end
      PH_BODY: begin
        push.v0        = 1'b1;
        push.v1        = body_end;
        res0.data_byte = byte_r;
        res0.last      = !body_end;
      end
      default: begin
        push = '0;
      end
    endcase
    if (!fire) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= 32'd0;
      hcount_r <= 5'd0;
      hsum_r   <= 16'd0;
      rem_r    <= 8'd0;
      crc_r    <= 32'hFFFF_FFFF;
      ackm_r   <= 2'd0;
      prev_r   <= 32'd0;
      fail_r   <= 32'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      hcount_r <= hcount_nxt;
      hsum_r   <= hsum_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      ackm_r   <= ackm_nxt;
      prev_r   <= prev_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // header bytes: no reset, always written before use
  always_ff @(posedge clk) begin
    if (fire && (phase_r == PH_HEADER)) begin
      hb_r[hcount_r[3:0]] <= byte_r;
    end
  end

endmodule

`default_nettype wire

[tb/framed_message_receiver_top_tb.sv]
// ----------------------------------------------------------------------------
// framed_message_receiver_top_tb
// Self-checking bench for the framed message receiver.
// ----------------------------------------------------------------------------
// Builds frames (start pattern, 16-byte header, body) and feeds them one byte
// per word, mixed with noise and broken frames. A deframer model in the bench
// tracks start hunting, header checks, CRC-32 and the ACK match, and queues
// the result words each byte should produce. Every word on the output is
// compared field by field with the oldest queued one. Both sides idle and
// stall at random in several phases, and one phase holds the output off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------

module framed_message_receiver_top_tb;
  import fmr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 175;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [31:0] out_msg_index;
  logic [31:0] out_body_length;
  logic        out_ack_wanted;
  logic        out_sequence_gap;
  logic [31:0] out_crc_fail_total;
  logic        out_last;

  framed_message_receiver_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_msg_index     (out_msg_index),
    .out_body_length   (out_body_length),
    .out_ack_wanted    (out_ack_wanted),
    .out_sequence_gap  (out_sequence_gap),
    .out_crc_fail_total(out_crc_fail_total),
    .out_last          (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Deframer model state
  res_t        expected_words[$];
  logic [31:0] pattern_reg = START_RESET;
  logic [7:0]  maxlen_reg  = MAXLEN_RESET;
  logic [31:0] win         = '0;
  phase_t      ph          = PH_HUNT;
  int          hcnt        = 0;
  logic [7:0]  hdr[16];
  logic [15:0] hsum        = '0;
  logic [7:0]  remain      = '0;
  logic [31:0] crc         = '1;
  logic [1:0]  ackm        = '0;
  logic [31:0] prev_idx    = '0;
  logic [31:0] fails       = '0;
  logic [7:0]  ack_text[3] = '{CHAR_A, CHAR_C, CHAR_K};

  int   mismatches  = 0;
  int   bytes_sent  = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   hold_left   = 0;
  bit   hold_req    = 1'b0;
  int   idle_cycles = 0;
  res_t want;

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] hdr_word32(input int at);
    return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
  endfunction

  function automatic void post_result(input kind_t k, input logic [7:0] d,
                                      input logic ack, input logic gap);
    res_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.msg_index      = hdr_word32(0);
    r.body_length    = hdr_word32(4);
    r.ack_wanted     = ack;
    r.sequence_gap   = gap;
    r.crc_fail_total = fails;
    r.last           = 1'b0;
    expected_words.push_back(r);
  endfunction

  function automatic void end_of_message();
    logic gap;
    logic ack;
    if (~crc == hdr_word32(8)) begin
      if (hdr_word32(4) == 32'd3 && ackm == 2'd3) begin
        post_result(KIND_ACK, 8'h00, 1'b0, 1'b0);
      end else begin
        gap = (hdr_word32(0) != prev_idx + 32'd1);
        ack = (hdr[12] != 8'h00);
        prev_idx = hdr_word32(0);
        post_result(KIND_GOOD, 8'h00, ack, gap);
      end
    end else begin
      fails = fails + 32'd1;
      post_result(KIND_CRC_ERR, 8'h00, 1'b0, 1'b0);
    end
    ph  = PH_HUNT;
    win = '0;
  endfunction

  // Expected result words for one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    int          depth_in;
    logic [31:0] lim;
    logic [7:0]  pos;
    res_t        r;
    depth_in = expected_words.size();
    case (ph)
      PH_HEADER: begin
        hdr[hcnt] = b;
        if (hcnt < 14) hsum = hsum + b;
        hcnt++;
        if (hcnt >= 16) begin
          lim  = {24'd0, (maxlen_reg > MAX_BODY) ? MAX_BODY : maxlen_reg};
          hcnt = 0;
          if (hdr_word32(4) > lim) begin
            post_result(KIND_LEN_ERR, 8'h00, 1'b0, 1'b0);
            ph = PH_HUNT;
          end else if (hsum != {hdr[15], hdr[14]}) begin
            post_result(KIND_HDR_ERR, 8'h00, 1'b0, 1'b0);
            ph = PH_HUNT;
          end else begin
            remain = hdr[4];
            crc    = '1;
            ackm   = '0;
            if (remain == 8'd0) end_of_message();
            else ph = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pos = 8'(hdr_word32(4) - {24'd0, remain});
        crc = crc_step(crc, b);
        if (pos < 3 && ackm == pos && b == ack_text[pos]) ackm++;
        post_result(KIND_BODY, b, 1'b0, 1'b0);
        if (remain > 0) remain--;
        if (remain == 0) end_of_message();
      end
      default: begin
        // hunting; a rejected header leaves the window holding the pattern
        ph  = PH_HUNT;
        win = {b, win[31:8]};
        if (win == pattern_reg) begin
          ph   = PH_HEADER;
          hcnt = 0;
          hsum = win[7:0] + win[15:8] + win[23:16] + win[31:24];
        end
      end
    endcase
    if (expected_words.size() > depth_in) begin
      r = expected_words.pop_back();
      r.last = 1'b1;
      expected_words.push_back(r);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [31:0] idx, input logic [31:0] len,
                            input byte_q_t body, input logic [7:0] ack_byte,
                            input bit bad_crc, input bit bad_sum, input bit with_start);
    logic [7:0]  hdr_out[16];
    logic [31:0] crc_v;
    logic [15:0] sum_v;
    crc_v = '1;
    foreach (body[i]) crc_v = crc_step(crc_v, body[i]);
    crc_v = ~crc_v;
    if (bad_crc) crc_v = crc_v ^ (32'd1 << $urandom_range(31));
    for (int i = 0; i < 4; i++) begin
      hdr_out[i]     = idx[8*i +: 8];
      hdr_out[4 + i] = len[8*i +: 8];
      hdr_out[8 + i] = crc_v[8*i +: 8];
    end
    hdr_out[12] = ack_byte;
    hdr_out[13] = 8'($urandom_range(255));
    sum_v = pattern_reg[7:0] + pattern_reg[15:8] + pattern_reg[23:16] + pattern_reg[31:24];
    for (int i = 0; i < 14; i++) sum_v = sum_v + hdr_out[i];
    if (bad_sum) sum_v = sum_v + 16'($urandom_range(1, 65535));
    hdr_out[14] = sum_v[7:0];
    hdr_out[15] = sum_v[15:8];
    if (with_start) begin
      for (int i = 0; i < 4; i++) send_byte(pattern_reg[8*i +: 8]);
    end
    foreach (hdr_out[i]) send_byte(hdr_out[i]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Lets the block go idle: all expected words out, then a few spare cycles
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_START) pattern_reg = val;
    else maxlen_reg = val[7:0];
  endtask

  task automatic set_regs(input logic [31:0] pat, input logic [7:0] maxl);
    drain();
    write_reg(REG_START, pat);
    write_reg(REG_MAXLEN, {24'd0, maxl});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_good_frames();
    byte_q_t body;
    body = '{8'h00, 8'hFF};
    send_frame(32'd1, 32'd2, body, 8'h01, 1'b0, 1'b0, 1'b1);
    body = '{8'h5A};
    send_frame(32'd7, 32'd1, body, 8'hFF, 1'b0, 1'b0, 1'b1);
    body = '{8'hFF, 8'hFF, 8'h00};
    send_frame(32'hFFFF_FFFF, 32'd3, body, 8'h00, 1'b0, 1'b0, 1'b1);
    // index wraps to zero: no gap
    body = '{8'h80};
    send_frame(32'd0, 32'd1, body, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_empty_body();
    byte_q_t body;
    body.delete();
    send_frame(prev_idx + 32'd1, 32'd0, body, 8'h01, 1'b0, 1'b0, 1'b1);
    send_frame(prev_idx + 32'd1, 32'd0, body, 8'h00, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_ack_message();
    byte_q_t body;
    body = '{CHAR_A, CHAR_C, CHAR_K};
    send_frame(32'd50, 32'd3, body, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(32'd51, 32'd3, body, 8'h00, 1'b1, 1'b0, 1'b1);
    body = '{CHAR_A, CHAR_C, 8'h58};
    send_frame(prev_idx + 32'd1, 32'd3, body, 8'h00, 1'b0, 1'b0, 1'b1);
    body = '{CHAR_A, CHAR_C, CHAR_K, 8'h00};
    send_frame(prev_idx + 32'd1, 32'd4, body, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_header_errors();
    byte_q_t body;
    body.delete();
    send_frame(32'd9, 32'd129, body, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(32'd9, 32'hFFFF_FFFF, body, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(32'd9, 32'd0, body, 8'h00, 1'b0, 1'b1, 1'b1);
    // length error wins over a bad checksum
    send_frame(32'd9, 32'd200, body, 8'h00, 1'b0, 1'b1, 1'b1);
    body = '{8'h12, 8'h34};
    send_frame(32'd9, 32'd2, body, 8'h00, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_length_limits();
    byte_q_t body;
    body.delete();
    set_regs(START_RESET, 8'd0);
    send_frame(prev_idx + 32'd1, 32'd0, body, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(prev_idx + 32'd1, 32'd1, body, 8'h00, 1'b0, 1'b0, 1'b1);
    // register above the hard cap: still limited to MAX_BODY
    set_regs(START_RESET, 8'hFF);
    send_frame(prev_idx + 32'd1, 32'd129, body, 8'h00, 1'b0, 1'b0, 1'b1);
    repeat (MAX_BODY) body.push_back(8'($urandom_range(255)));
    send_frame(prev_idx + 32'd1, 32'd128, body, 8'h01, 1'b0, 1'b0, 1'b1);
    set_regs(START_RESET, 8'd1);
    body = '{8'hC3};
    send_frame(prev_idx + 32'd1, 32'd1, body, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(prev_idx + 32'd1, 32'd2, body, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_window_after_reject();
    byte_q_t body;
    body.delete();
    set_regs(32'hAAAA_AAAA, MAXLEN_RESET);
    send_frame(32'd5, 32'd2, body, 8'h00, 1'b0, 1'b1, 1'b1);
    // window still holds the pattern, one more byte re-syncs
    send_byte(8'hAA);
    body = '{8'h01, 8'h02};
    send_frame(32'd6, 32'd2, body, 8'h01, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_zero_pattern();
    byte_q_t body;
    set_regs(32'h0000_0000, MAXLEN_RESET);
    // window is clear after the last frame, so a single zero syncs
    send_byte(8'h00);
    body = '{8'h00};
    send_frame(prev_idx + 32'd1, 32'd1, body, 8'h00, 1'b0, 1'b0, 1'b0);
    set_regs(32'hFFFF_FFFF, MAXLEN_RESET);
    body = '{8'hFF, 8'h00};
    send_frame(prev_idx + 32'd1, 32'd2, body, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    byte_q_t body;
    set_regs(START_RESET, MAXLEN_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    body.delete();
    repeat (40) body.push_back(8'($urandom_range(255)));
    hold_req = 1'b1;
    send_frame(prev_idx + 32'd1, 32'd40, body, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [31:0] pat, input logic [7:0] maxl);
    byte_q_t     body;
    int          stop_at;
    int          pick;
    int          lim;
    int          len;
    logic [31:0] idx;
    logic [31:0] bad_len;
    idle_pct  = idle;
    stall_pct = stall;
    set_regs(pat, maxl);
    lim     = int'((maxl > MAX_BODY) ? MAX_BODY : maxl);
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      idx  = ($urandom_range(3) != 0) ? prev_idx + 32'd1 : $urandom;
      len  = ($urandom_range(6) != 0) ? $urandom_range(lim < 12 ? lim : 12)
                                      : $urandom_range(lim);
      body.delete();
      repeat (len) body.push_back(8'($urandom_range(255)));
      if (pick < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else if (pick < 14) begin
        body.delete();
        bad_len = $urandom_range(1) ? lim + 1 + $urandom_range(200)
                                    : ($urandom | 32'h8000_0000);
        send_frame(idx, bad_len, body, 8'h00, 1'b0, $urandom_range(3) == 0, 1'b1);
      end else if (pick < 20) begin
        send_frame(idx, len, body, 8'h00, 1'b0, 1'b1, 1'b1);
      end else if (pick < 28) begin
        send_frame(idx, len, body, 8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
      end else if (pick < 34) begin
        body = '{CHAR_A, CHAR_C, CHAR_K};
        send_frame(idx, 32'd3, body, 8'h00, $urandom_range(4) == 0, 1'b0, 1'b1);
      end else begin
        send_frame(idx, len, body, $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255)),
                   1'b0, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Output stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: word expected none actual kind %0d data %0h", $time,
                 out_kind, out_data_byte);
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("msg_index", want.msg_index, out_msg_index);
        check_field("body_length", want.body_length, out_body_length);
        check_field("ack_wanted", want.ack_wanted, out_ack_wanted);
        check_field("sequence_gap", want.sequence_gap, out_sequence_gap);
        check_field("crc_fail_total", want.crc_fail_total, out_crc_fail_total);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_START;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_stall  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_good_frames();
    test_empty_body();
    test_ack_message();
    test_header_errors();
    set_regs(START_RESET, MAXLEN_RESET);
    test_length_limits();
    test_window_after_reject();
    test_zero_pattern();
    test_backpressure();
    test_random_traffic(0, 0, START_RESET, MAXLEN_RESET);
    test_random_traffic(57, 0, $urandom, 8'($urandom_range(1, 128)));
    test_random_traffic(0, 57, 32'hFFFF_FFFF, 8'd64);
    test_random_traffic(30, 30, $urandom, MAXLEN_RESET);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
